[rtl/tiny8_pkg.sv]
// shared types and constants for the tiny 8-bit execute unit
// no dependencies
`default_nettype none

package tiny8_pkg;

	localparam logic [2:0] OP_ADD = 3'b000;
	localparam logic [2:0] OP_MOV = 3'b001;
	localparam logic [2:0] OP_SUB = 3'b010;
	localparam logic [2:0] OP_LD  = 3'b011;
	localparam logic [2:0] OP_ST  = 3'b100;
	localparam logic [2:0] OP_JMP = 3'b101;
	localparam logic [2:0] OP_AND = 3'b110;
	localparam logic [2:0] OP_OR  = 3'b111;

	localparam logic [1:0] KIND_REG  = 2'd0;
	localparam logic [1:0] KIND_MEM  = 2'd1;
	localparam logic [1:0] KIND_JUMP = 2'd2;

	localparam logic [7:0] RF_RESET_0 = 8'd4;
	localparam logic [7:0] RF_RESET_1 = 8'd8;
	localparam logic [7:0] RF_RESET_2 = 8'd5;
	localparam logic [7:0] RF_RESET_3 = 8'd3;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] rd;
		logic [2:0] src;
	} decoded_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

[rtl/tiny8_front.sv]
// front stage: accepts instruction words and splits them into decoded fields
// depends on tiny8_pkg
`default_nettype none

module tiny8_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                inst_valid,
	output logic                     inst_stall,
	input  wire logic [7:0]          instruction,
	input  wire tiny8_pkg::queue_stat_t q_stat,
	output logic                     push_valid,
	output tiny8_pkg::decoded_t      push_item
);

	logic                valid_s1;
	tiny8_pkg::decoded_t item_s1;
	logic                take;
	logic                push;

	assign push       = valid_s1 && !q_stat.full;
	assign inst_stall = valid_s1 && q_stat.full;
	assign take       = inst_valid && !inst_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op  <= instruction[7:5];
			item_s1.rd  <= instruction[4:3];
			item_s1.src <= instruction[2:0];
		end
	end

endmodule

`default_nettype wire

[rtl/tiny8_queue.sv]
// two-entry queue of decoded instructions between front and back
// depends on tiny8_pkg
`default_nettype none

module tiny8_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	input  wire tiny8_pkg::decoded_t push_item,
	output tiny8_pkg::queue_stat_t   q_stat,
	input  wire logic                pop,
	output tiny8_pkg::decoded_t      head_item
);

	tiny8_pkg::decoded_t ent_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                do_push;
	logic                do_pop;

	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);
	assign do_push      = push_valid && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_item    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[rtl/tiny8_back.sv]
// back stage: register file, data memory, pc, execution and result register
// depends on tiny8_pkg
`default_nettype none

module tiny8_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [8:0]          cfg_data,
	input  wire tiny8_pkg::queue_stat_t q_stat,
	input  wire tiny8_pkg::decoded_t head_item,
	output logic                     pop,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output logic [7:0]               next_pc,
	output logic                     finished,
	output logic [1:0]               write_kind,
	output logic [2:0]               write_index,
	output logic [7:0]               write_value
);

	logic [7:0] rf_q [4];
	logic [7:0] mem_q [8];
	logic [7:0] pc_q;
	logic [8:0] prog_len_q;
	logic       out_valid_q;
	logic [7:0] next_pc_q;
	logic       finished_q;
	logic [1:0] kind_q;
	logic [2:0] index_q;
	logic [7:0] value_q;

	logic [7:0] rd_val;
	logic [7:0] rs_val;
	logic [7:0] mem_val;
	logic [7:0] reg_new;
	logic [1:0] kind;
	logic [2:0] widx;
	logic [7:0] wval;
	logic [7:0] npc;
	logic       fin;

	assign cfg_ready = 1'b1;
	assign pop       = !q_stat.empty && (!out_valid_q || !res_stall);

	assign rd_val  = rf_q[head_item.rd];
	assign rs_val  = rf_q[head_item.src[1:0]];
	assign mem_val = mem_q[head_item.src];

	always_comb begin
		reg_new = rd_val;
		kind    = tiny8_pkg::KIND_REG;
		widx    = {1'b0, head_item.rd};
		npc     = pc_q + 8'd1;
		unique case (head_item.op)
			tiny8_pkg::OP_ADD: begin
				reg_new = rd_val + rs_val;
			end
			tiny8_pkg::OP_MOV: begin
				reg_new = {5'd0, head_item.src};
			end
			tiny8_pkg::OP_SUB: begin
				reg_new = rd_val - rs_val;
			end
			tiny8_pkg::OP_LD: begin
				reg_new = mem_val;
			end
			tiny8_pkg::OP_ST: begin
				kind = tiny8_pkg::KIND_MEM;
				widx = head_item.src;
			end
			tiny8_pkg::OP_JMP: begin
				kind = tiny8_pkg::KIND_JUMP;
				widx = head_item.src;
				npc  = {5'd0, head_item.src};
			end
			tiny8_pkg::OP_AND: begin
				reg_new = rd_val & rs_val;
			end
			tiny8_pkg::OP_OR: begin
				reg_new = rd_val | rs_val;
			end
			default: begin
				reg_new = rd_val;
			end
		endcase
		case (kind)
			tiny8_pkg::KIND_MEM:  wval = rd_val;
			tiny8_pkg::KIND_JUMP: wval = {5'd0, head_item.src};
			default:              wval = reg_new;
		endcase
		fin = ({1'b0, npc} >= prog_len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q[0]     <= tiny8_pkg::RF_RESET_0;
			rf_q[1]     <= tiny8_pkg::RF_RESET_1;
			rf_q[2]     <= tiny8_pkg::RF_RESET_2;
			rf_q[3]     <= tiny8_pkg::RF_RESET_3;
			for (int i = 0; i < 8; i++) begin
				mem_q[i] <= 8'd0;
			end
			pc_q        <= 8'd0;
			prog_len_q  <= 9'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				prog_len_q <= cfg_data;
			end
			if (pop) begin
				pc_q        <= npc;
				out_valid_q <= 1'b1;
				if (kind == tiny8_pkg::KIND_REG) begin
					rf_q[head_item.rd] <= reg_new;
				end
				if (kind == tiny8_pkg::KIND_MEM) begin
					mem_q[head_item.src] <= rd_val;
				end
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			next_pc_q  <= npc;
			finished_q <= fin;
			kind_q     <= kind;
			index_q    <= widx;
			value_q    <= wval;
		end
	end

	assign res_valid   = out_valid_q;
	assign next_pc     = next_pc_q;
	assign finished    = finished_q;
	assign write_kind  = kind_q;
	assign write_index = index_q;
	assign write_value = value_q;

endmodule

`default_nettype wire

[rtl/tiny8_bit_isa_execute_unit.sv]
// tiny 8-bit execute unit, top level: front decode, queue, back execute
// a word passes the front register, a queue entry and the result register
// throughput one instruction per clock while res_stall does not hold the back
// reset clears pc, program length, data memory and loads registers with 4, 8, 5, 3
// depends on tiny8_pkg, tiny8_front, tiny8_queue, tiny8_back
`default_nettype none

module tiny_8bit_isa_execute_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data,
	input  wire logic       inst_valid,
	output logic            inst_stall,
	input  wire logic [7:0] instruction,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      next_pc,
	output logic            finished,
	output logic [1:0]      write_kind,
	output logic [2:0]      write_index,
	output logic [7:0]      write_value
);

	tiny8_pkg::queue_stat_t q_stat;
	tiny8_pkg::decoded_t    push_item;
	tiny8_pkg::decoded_t    head_item;
	logic                   push_valid;
	logic                   pop;

	tiny8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.inst_valid  (inst_valid),
		.inst_stall  (inst_stall),
		.instruction (instruction),
		.q_stat      (q_stat),
		.push_valid  (push_valid),
		.push_item   (push_item)
	);

	tiny8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_stat     (q_stat),
		.pop        (pop),
		.head_item  (head_item)
	);

	tiny8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_stat      (q_stat),
		.head_item   (head_item),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.next_pc     (next_pc),
		.finished    (finished),
		.write_kind  (write_kind),
		.write_index (write_index),
		.write_value (write_value)
	);

	a_jump_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && write_kind == tiny8_pkg::KIND_JUMP |->
			next_pc == {5'd0, write_index} && write_value == {5'd0, write_index})
		else $error("jump word inconsistent");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	a_pop_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_valid)
		else $error("executed word not presented");

	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inst_stall |-> q_stat.full && push_valid)
		else $error("front stalls with room in queue");

endmodule

`default_nettype wire

[sim/tiny_8bit_isa_execute_unit_tb.sv]
// self-checking testbench for tiny_8bit_isa_execute_unit: directed and random programs
// run through an instruction-level predictor, with random idling on both channels
// depends on tiny8_pkg and the execute unit rtl
`default_nettype none

module tiny_8bit_isa_execute_unit_tb;

	typedef struct packed {
		logic [7:0] npc;
		logic       fin;
		logic [1:0] kind;
		logic [2:0] idx;
		logic [7:0] val;
	} step_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] cfg_data = 9'd0;
	logic       inst_valid = 1'b0;
	logic       inst_stall;
	logic [7:0] instruction = 8'd0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] next_pc;
	logic       finished;
	logic [1:0] write_kind;
	logic [2:0] write_index;
	logic [7:0] write_value;

	logic [7:0] core_regs [4] = '{tiny8_pkg::RF_RESET_0, tiny8_pkg::RF_RESET_1,
		tiny8_pkg::RF_RESET_2, tiny8_pkg::RF_RESET_3};
	logic [7:0] core_mem [8] = '{default: 8'd0};
	logic [7:0] core_pc = 8'd0;
	logic [8:0] core_length = 9'd0;

	logic [7:0]   program_words [$];
	step_result_t predicted_results [$];

	int  send_gap = 0;
	bit  send_burst = 1'b0;
	int  recv_wait = 0;
	bit  recv_burst = 1'b0;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  mismatch_count = 0;
	int  idle_cycles = 0;

	tiny_8bit_isa_execute_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.inst_valid  (inst_valid),
		.inst_stall  (inst_stall),
		.instruction (instruction),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.next_pc     (next_pc),
		.finished    (finished),
		.write_kind  (write_kind),
		.write_index (write_index),
		.write_value (write_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic step_result_t execute_instruction(input logic [7:0] word);
		tiny8_pkg::decoded_t dec;
		step_result_t        res;
		logic [1:0]          sreg;
		dec = word;
		sreg = dec.src[1:0];
		res.npc = core_pc + 8'd1;
		res.kind = tiny8_pkg::KIND_REG;
		res.idx = {1'b0, dec.rd};
		res.val = 8'd0;
		case (dec.op)
			tiny8_pkg::OP_ADD: core_regs[dec.rd] = core_regs[dec.rd] + core_regs[sreg];
			tiny8_pkg::OP_MOV: core_regs[dec.rd] = {5'd0, dec.src};
			tiny8_pkg::OP_SUB: core_regs[dec.rd] = core_regs[dec.rd] - core_regs[sreg];
			tiny8_pkg::OP_LD:  core_regs[dec.rd] = core_mem[dec.src];
			tiny8_pkg::OP_ST: begin
				core_mem[dec.src] = core_regs[dec.rd];
				res.kind = tiny8_pkg::KIND_MEM;
				res.idx = dec.src;
				res.val = core_regs[dec.rd];
			end
			tiny8_pkg::OP_JMP: begin
				res.kind = tiny8_pkg::KIND_JUMP;
				res.idx = dec.src;
				res.val = {5'd0, dec.src};
				res.npc = {5'd0, dec.src};
			end
			tiny8_pkg::OP_AND: core_regs[dec.rd] = core_regs[dec.rd] & core_regs[sreg];
			default: core_regs[dec.rd] = core_regs[dec.rd] | core_regs[sreg];
		endcase
		if (res.kind == tiny8_pkg::KIND_REG)
			res.val = core_regs[dec.rd];
		core_pc = res.npc;
		res.fin = ({1'b0, res.npc} >= core_length);
		return res;
	endfunction

	function automatic logic [7:0] random_instruction(input int jump_pct);
		logic [2:0] op;
		if ($urandom_range(99) < jump_pct) begin
			op = tiny8_pkg::OP_JMP;
		end else begin
			op = 3'($urandom_range(6));
			if (op >= tiny8_pkg::OP_JMP)
				op = op + 3'd1;
		end
		return {op, 5'($urandom)};
	endfunction

	// driver: one word per accept, random gap before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_valid <= 1'b0;
		end else begin
			if (inst_valid && !inst_stall) begin
				predicted_results.push_back(execute_instruction(instruction));
				void'(program_words.pop_front());
				if ($urandom_range(31) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(7);
			end
			if (inst_valid && inst_stall) begin
				inst_valid <= 1'b1;
			end else if (send_gap == 0 && program_words.size() > 0) begin
				inst_valid <= 1'b1;
				instruction <= program_words[0];
			end else begin
				inst_valid <= 1'b0;
				if (send_gap > 0)
					send_gap = send_gap - 1;
			end
		end
	end

	// monitor: compares each accepted word, then draws its own stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				step_result_t got;
				step_result_t want;
				got = '{next_pc, finished, write_kind, write_index, write_value};
				if (predicted_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: npc %0d fin %0d kind %0d idx %0d val %0d",
							got.npc, got.fin, got.kind, got.idx, got.val);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = predicted_results.pop_front();
					if (got.npc !== want.npc || got.fin !== want.fin || got.kind !== want.kind
						|| got.idx !== want.idx || got.val !== want.val) begin
						if (mismatch_count < 10) begin
							$display("mismatch: want npc %0d fin %0d kind %0d idx %0d val %0d",
								want.npc, want.fin, want.kind, want.idx, want.val);
							$display("          got  npc %0d fin %0d kind %0d idx %0d val %0d",
								got.npc, got.fin, got.kind, got.idx, got.val);
						end
						mismatch_count = mismatch_count + 1;
					end
				end
				if ($urandom_range(31) == 0)
					recv_burst = !recv_burst;
				recv_wait = recv_burst ? 0 : $urandom_range(7);
			end
			// long hold-off so the block backs up into its input
			if (hold_requests != hold_served) begin
				recv_wait = 80;
				hold_served = hold_served + 1;
			end
			if (recv_wait > 0) begin
				res_stall <= 1'b1;
				recv_wait = recv_wait - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((inst_valid && !inst_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= 1000) begin
				$display("tiny_8bit_isa_execute_unit_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic write_program_length(input logic [8:0] len);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		core_length = len;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (program_words.size() > 0 || predicted_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic play_random_block(input logic [8:0] len, input int count,
		input int jump_pct, input bit hold_off);
		write_program_length(len);
		@(negedge clk);
		if (hold_off)
			hold_requests = hold_requests + 1;
		repeat (count)
			program_words.push_back(random_instruction(jump_pct));
		wait_drained();
	endtask

	initial begin
		logic [7:0] directed [$];
		directed = '{
			{tiny8_pkg::OP_MOV, 2'd0, 3'd7}, {tiny8_pkg::OP_MOV, 2'd3, 3'd0},
			{tiny8_pkg::OP_ADD, 2'd1, 3'd2}, {tiny8_pkg::OP_ADD, 2'd2, 3'd6},
			{tiny8_pkg::OP_SUB, 2'd3, 3'd0}, {tiny8_pkg::OP_SUB, 2'd3, 3'd7},
			{tiny8_pkg::OP_LD, 2'd2, 3'd7}, {tiny8_pkg::OP_ST, 2'd3, 3'd7},
			{tiny8_pkg::OP_LD, 2'd1, 3'd7}, {tiny8_pkg::OP_ST, 2'd0, 3'd0},
			{tiny8_pkg::OP_ADD, 2'd3, 3'd3}, {tiny8_pkg::OP_AND, 2'd3, 3'd5},
			{tiny8_pkg::OP_OR, 2'd0, 3'd3}, {tiny8_pkg::OP_OR, 2'd1, 3'd4},
			{tiny8_pkg::OP_JMP, 2'd3, 3'd7}, {tiny8_pkg::OP_JMP, 2'd0, 3'd0},
			{tiny8_pkg::OP_MOV, 2'd2, 3'd7}, 8'hFF, 8'h00,
			{tiny8_pkg::OP_ST, 2'd1, 3'd4}, {tiny8_pkg::OP_LD, 2'd0, 3'd4}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// short program, runs past its end and jumps back inside it
		write_program_length(9'd3);
		@(negedge clk);
		foreach (directed[i])
			program_words.push_back(directed[i]);
		wait_drained();

		play_random_block(9'd256, 300, 0, 1'b1);
		play_random_block(9'd0, 100, 12, 1'b0);
		play_random_block(9'd1, 100, 12, 1'b0);
		play_random_block(9'($urandom_range(255, 2)), 150, 3, 1'b0);
		play_random_block(9'd255, 150, 1, 1'b0);
		play_random_block(9'($urandom_range(256)), 100, 12, 1'b1);

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("tiny_8bit_isa_execute_unit_tb OK");
		else
			$display("tiny_8bit_isa_execute_unit_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
